@@ rtl/core/ihf_pkg.sv @@
// Shared types and constants for the IPv4 fragment header generator.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package ihf_pkg;

   // Header constants
   localparam logic [15:0] HDR_BYTES   = 16'd20;
   localparam logic [15:0] MIN_MTU     = 16'd1044;
   localparam logic [15:0] RESET_MTU   = 16'd1500;
   localparam logic [3:0]  IP_VERSION  = 4'd4;
   localparam logic [3:0]  IP_IHL      = 4'd5;
   localparam logic [7:0]  IP_TTL      = 8'd255;
   localparam logic [15:0] CHUNK_ALIGN = 16'hFFF8;

   // Configuration register indexes
   localparam logic REG_MTU        = 1'b0;
   localparam logic REG_LOCAL_ADDR = 1'b1;

   // Widths
   localparam int unsigned SUM_W  = 20;
   localparam int unsigned BASE_W = 19;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_EMIT,
      ST_DRAIN
   } ihf_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // latch the request and take an identification value
      logic prep;   // work out chunk size, fit test and fixed checksum part
      logic issue;  // build the next fragment header into stage one
   } ihf_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic advance;   // pipeline moves this cycle
      logic final_frag;// the fragment at the current offset is the last one
      logic s1_busy;   // stage one still holds a header
   } ihf_status_type;

endpackage : ihf_pkg

@@ rtl/core/ipv4_header_fragmenter.sv @@
// Top level of the IPv4 fragment header generator.
// Instantiates ihf_ctrl and ihf_datapath; depends on ihf_pkg.
//
//   Channel   Direction  Handshake                 Contents
//   req_      in         req_valid / req_ready     one outgoing packet request
//   rsp_      out        rsp_valid / rsp_ready     one fragment header
//   csr_      in         csr_wr_en                 mtu (index 0), local address (1)
//
// A request passes through acceptance, a preparation state, one header per cycle
// into the fragment stage while the result side does not stall, then a drain state
// until the last header has left the fragment stage for the output register, and a
// return to idle.
// Synchronous reset sets mtu to 1500, the local address and identification to 0.
// A stalled result holds the pipeline; the next request is taken after the last
// header of the current packet reaches the output register and the drain ends.
`timescale 1ns / 1ps

module ipv4_header_fragmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_payload_length,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_service_type,
   input  logic [7:0]  req_proto_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_total_length,
   output logic [15:0] rsp_ident,
   output logic [12:0] rsp_frag_offset,
   output logic        rsp_more_fragments,
   output logic        rsp_dont_fragment,
   output logic [15:0] rsp_header_checksum,
   output logic [15:0] rsp_payload_start,
   output logic        rsp_last
);
   import ihf_pkg::*;

   ihf_cmd_type    cmd;
   ihf_status_type status;

   // Sequencing of one request
   ihf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Header fields and checksum
   ihf_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_payload_length  (req_payload_length),
      .req_dest_address    (req_dest_address),
      .req_service_type    (req_service_type),
      .req_proto_number    (req_proto_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_ident           (rsp_ident),
      .rsp_frag_offset     (rsp_frag_offset),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_dont_fragment   (rsp_dont_fragment),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_last            (rsp_last)
   );

endmodule : ipv4_header_fragmenter

@@ rtl/core/ihf_ctrl.sv @@
// Controller state machine for the IPv4 fragment header generator.
// Depends on ihf_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ihf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ihf_pkg::ihf_status_type status,
   output ihf_pkg::ihf_cmd_type    cmd
);
   import ihf_pkg::*;

   ihf_state_type state_ff;
   ihf_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.advance && status.final_frag) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.s1_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_EMIT: begin
            cmd.issue = status.advance;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule : ihf_ctrl

@@ rtl/core/ihf_datapath.sv @@
// Datapath of the IPv4 fragment header generator: configuration registers,
// request registers, fragment stage and output register. Depends on ihf_pkg.
`timescale 1ns / 1ps

module ihf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ihf_pkg::ihf_cmd_type    cmd,
   output ihf_pkg::ihf_status_type status,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [31:0]             csr_wr_data,
   input  logic [15:0]             req_payload_length,
   input  logic [31:0]             req_dest_address,
   input  logic [7:0]              req_service_type,
   input  logic [7:0]              req_proto_number,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_total_length,
   output logic [15:0]             rsp_ident,
   output logic [12:0]             rsp_frag_offset,
   output logic                    rsp_more_fragments,
   output logic                    rsp_dont_fragment,
   output logic [15:0]             rsp_header_checksum,
   output logic [15:0]             rsp_payload_start,
   output logic                    rsp_last
);
   import ihf_pkg::*;

   // Configuration and identification counter
   logic [15:0] mtu_ff;
   logic [31:0] laddr_ff;
   logic [15:0] ident_cnt_ff;

   // Request registers
   logic [15:0] len_ff;
   logic [31:0] dst_ff;
   logic [7:0]  tos_ff;
   logic [7:0]  proto_ff;
   logic [15:0] ident_ff;

   // Per-packet values worked out in the preparation cycle
   logic [15:0]       chunk_ff;
   logic              fits_ff;
   logic [BASE_W-1:0] base_ff;
   logic [15:0]       offset_ff;

   // Stage one: fragment fields
   logic        s1_valid_ff;
   logic [15:0] s1_tot_ff;
   logic [12:0] s1_frag_ff;
   logic        s1_mf_ff;
   logic        s1_df_ff;
   logic [15:0] s1_start_ff;
   logic        s1_last_ff;

   // Output register
   logic        out_valid_ff;
   logic [15:0] out_tot_ff;
   logic [15:0] out_ident_ff;
   logic [12:0] out_frag_ff;
   logic        out_mf_ff;
   logic        out_df_ff;
   logic [15:0] out_csum_ff;
   logic [15:0] out_start_ff;
   logic        out_last_ff;

   logic              advance;
   logic [15:0]       mtu_eff;
   logic              fits_now;
   logic [15:0]       chunk_now;
   logic [BASE_W-1:0] base_now;
   logic              final_now;
   logic [16:0]       next_end;
   logic [15:0]       tot_now;
   logic [15:0]       frag_word;
   logic [SUM_W-1:0]  csum_sum;
   logic [16:0]       csum_fold1;
   logic [15:0]       csum_fold2;

   // The pipeline moves whenever the output register is free or being taken
   assign advance = !out_valid_ff || rsp_ready;

   // Configuration writes and identification counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mtu_ff       <= RESET_MTU;
         laddr_ff     <= '0;
         ident_cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_MTU:        mtu_ff   <= csr_wr_data[15:0];
               REG_LOCAL_ADDR: laddr_ff <= csr_wr_data;
               default:        mtu_ff   <= mtu_ff;
            endcase
         end
         if (cmd.load) ident_cnt_ff <= ident_cnt_ff + 16'd1;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff   <= req_payload_length;
         dst_ff   <= req_dest_address;
         tos_ff   <= req_service_type;
         proto_ff <= req_proto_number;
         ident_ff <= ident_cnt_ff;
      end
   end

   // Effective MTU, fit test, chunk size and the fixed part of the checksum sum
   always_comb begin
      mtu_eff   = (mtu_ff < MIN_MTU) ? MIN_MTU : mtu_ff;
      fits_now  = ({1'b0, len_ff} + {1'b0, HDR_BYTES}) <= {1'b0, mtu_eff};
      chunk_now = (mtu_eff - HDR_BYTES) & CHUNK_ALIGN;
      base_now  = BASE_W'({IP_VERSION, IP_IHL, tos_ff})
                + BASE_W'(ident_ff)
                + BASE_W'({IP_TTL, proto_ff})
                + BASE_W'(laddr_ff[31:16])
                + BASE_W'(laddr_ff[15:0])
                + BASE_W'(dst_ff[31:16])
                + BASE_W'(dst_ff[15:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         chunk_ff <= chunk_now;
         fits_ff  <= fits_now;
         base_ff  <= base_now;
      end
   end

   // Fragment at the current offset; with chunks of at least 1024 bytes a
   // packet never needs more than 64 of them, so no count limit is kept.
   always_comb begin
      next_end  = {1'b0, offset_ff} + {1'b0, chunk_ff};
      final_now = fits_ff || (next_end >= {1'b0, len_ff});
      if (fits_ff) begin
         tot_now = len_ff + HDR_BYTES;
      end else if (final_now) begin
         tot_now = HDR_BYTES + len_ff - offset_ff;
      end else begin
         tot_now = HDR_BYTES + chunk_ff;
      end
   end

   // Offset walk
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         offset_ff <= '0;
      end else if (cmd.issue) begin
         offset_ff <= next_end[15:0];
      end
   end

   // Stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (cmd.issue) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_tot_ff   <= tot_now;
         s1_frag_ff  <= fits_ff ? 13'd0 : offset_ff[15:3];
         s1_mf_ff    <= !final_now;
         s1_df_ff    <= fits_ff;
         s1_start_ff <= fits_ff ? 16'd0 : offset_ff;
         s1_last_ff  <= final_now;
      end
   end

   // Header checksum: fixed part plus length and flags word, folded twice
   always_comb begin
      frag_word  = {1'b0, s1_df_ff, s1_mf_ff, s1_frag_ff};
      csum_sum   = SUM_W'(base_ff) + SUM_W'(s1_tot_ff) + SUM_W'(frag_word);
      csum_fold1 = {1'b0, csum_sum[15:0]} + 17'(csum_sum[SUM_W-1:16]);
      csum_fold2 = csum_fold1[15:0] + 16'(csum_fold1[16]);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_tot_ff   <= s1_tot_ff;
         out_ident_ff <= ident_ff;
         out_frag_ff  <= s1_frag_ff;
         out_mf_ff    <= s1_mf_ff;
         out_df_ff    <= s1_df_ff;
         out_csum_ff  <= ~csum_fold2;
         out_start_ff <= s1_start_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   // Status back to the controller
   always_comb begin
      status.advance    = advance;
      status.final_frag = final_now;
      status.s1_busy    = s1_valid_ff;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_total_length    = out_tot_ff;
   assign rsp_ident           = out_ident_ff;
   assign rsp_frag_offset     = out_frag_ff;
   assign rsp_more_fragments  = out_mf_ff;
   assign rsp_dont_fragment   = out_df_ff;
   assign rsp_header_checksum = out_csum_ff;
   assign rsp_payload_start   = out_start_ff;
   assign rsp_last            = out_last_ff;

endmodule : ihf_datapath

@@ tb/sv/tb_ipv4_header_fragmenter.sv @@
// Self-checking testbench for the IPv4 fragment header generator.
// Drives ipv4_header_fragmenter through its request, result and register ports;
// depends on ihf_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_ipv4_header_fragmenter;
   import ihf_pkg::*;

   localparam logic [15:0] FLAG_MF      = 16'h2000;
   localparam logic [15:0] FLAG_DF      = 16'h4000;
   localparam int unsigned MAX_FRAGS    = 64;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned SETTLE_TICKS = 8;

   // One expected fragment header
   typedef struct {
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [12:0] frag_offset;
      logic        more_fragments;
      logic        dont_fragment;
      logic [15:0] header_checksum;
      logic [15:0] payload_start;
      logic        last;
   } frag_header_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = REG_MTU;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_payload_length = '0;
   logic [31:0] req_dest_address = '0;
   logic [7:0]  req_service_type = '0;
   logic [7:0]  req_proto_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_total_length;
   logic [15:0] rsp_ident;
   logic [12:0] rsp_frag_offset;
   logic        rsp_more_fragments;
   logic        rsp_dont_fragment;
   logic [15:0] rsp_header_checksum;
   logic [15:0] rsp_payload_start;
   logic        rsp_last;

   // Predictor state and configuration shadow
   logic [15:0] cfg_mtu = RESET_MTU;
   logic [31:0] cfg_local_addr = '0;
   logic [15:0] ident_next = '0;
   frag_header_type pending_headers[$];

   int unsigned requests_sent = 0;
   int unsigned headers_checked = 0;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   ipv4_header_fragmenter u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_payload_length  (req_payload_length),
      .req_dest_address    (req_dest_address),
      .req_service_type    (req_service_type),
      .req_proto_number    (req_proto_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_ident           (rsp_ident),
      .rsp_frag_offset     (rsp_frag_offset),
      .rsp_more_fragments  (rsp_more_fragments),
      .rsp_dont_fragment   (rsp_dont_fragment),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_last            (rsp_last)
   );

   always #1 clock = ~clock;

   // One's-complement sum of the nine non-checksum header words, folded and inverted.
   function automatic logic [15:0] ip_header_checksum(input logic [7:0] tos,
                                                      input logic [15:0] tot,
                                                      input logic [15:0] id,
                                                      input logic [15:0] flag_word,
                                                      input logic [7:0] proto,
                                                      input logic [31:0] dst);
      logic [19:0] acc;
      acc = {IP_VERSION, IP_IHL, tos} + tot + id + flag_word + {IP_TTL, proto}
            + cfg_local_addr[31:16] + cfg_local_addr[15:0] + dst[31:16] + dst[15:0];
      acc = acc[15:0] + acc[19:16];
      acc = acc[15:0] + acc[19:16];
      return ~acc[15:0];
   endfunction

   // Works out every fragment header that one accepted request must produce.
   function automatic void predict_fragments(input logic [15:0] len, input logic [31:0] dst,
                                             input logic [7:0] tos, input logic [7:0] proto);
      int unsigned     plen;
      int unsigned     eff_mtu;
      int unsigned     chunk;
      int unsigned     offset;
      int unsigned     count;
      logic [15:0]     id;
      logic [15:0]     word;
      bit              is_final;
      frag_header_type hdr;
      plen = len;
      eff_mtu = (cfg_mtu < MIN_MTU) ? MIN_MTU : cfg_mtu;
      id = ident_next;
      ident_next = ident_next + 16'd1;
      // A packet that fits goes out whole with DF set.
      if (plen + HDR_BYTES <= eff_mtu) begin
         hdr.total_length    = 16'(plen + HDR_BYTES);
         hdr.ident           = id;
         hdr.frag_offset     = '0;
         hdr.more_fragments  = 1'b0;
         hdr.dont_fragment   = 1'b1;
         hdr.header_checksum = ip_header_checksum(tos, hdr.total_length, id, FLAG_DF, proto, dst);
         hdr.payload_start   = '0;
         hdr.last            = 1'b1;
         pending_headers.push_back(hdr);
         return;
      end
      // Otherwise cut into 8-byte aligned chunks, MF on all but the final one.
      chunk = (eff_mtu - HDR_BYTES) & ~32'd7;
      count = 0;
      for (offset = 0; offset < plen && count < MAX_FRAGS; offset += chunk) begin
         is_final = (offset >= plen - chunk);
         hdr.total_length = is_final ? 16'(HDR_BYTES + plen - offset) : 16'(HDR_BYTES + chunk);
         word = {3'b000, 13'(offset >> 3)};
         if (!is_final)
            word = word | FLAG_MF;
         hdr.ident           = id;
         hdr.frag_offset     = 13'(offset >> 3);
         hdr.more_fragments  = !is_final;
         hdr.dont_fragment   = 1'b0;
         hdr.header_checksum = ip_header_checksum(tos, hdr.total_length, id, word, proto, dst);
         hdr.payload_start   = offset[15:0];
         hdr.last            = is_final;
         pending_headers.push_back(hdr);
         count++;
      end
   endfunction

   // Offers one request, holds it until accepted, then records its expected headers.
   task automatic send_request(input logic [15:0] len, input logic [31:0] dst,
                               input logic [7:0] tos, input logic [7:0] proto);
      int unsigned gap;
      gap = (req_idle_on && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_payload_length <= len;
      req_dest_address   <= dst;
      req_service_type   <= tos;
      req_proto_number   <= proto;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_fragments(len, dst, tos, proto);
      requests_sent++;
   endtask

   // Random request with most lengths small and a few reaching the top of the range.
   task automatic send_random_request();
      int unsigned pick;
      logic [15:0] len;
      pick = $urandom_range(99);
      if (pick < 55)
         len = 16'($urandom_range(0, 1500));
      else if (pick < 80)
         len = 16'($urandom_range(1501, 9000));
      else if (pick < 92)
         len = 16'($urandom_range(9001, 65535));
      else if (pick < 96)
         len = 16'($urandom_range(0, 40));
      else
         len = 16'(65535 - $urandom_range(0, 40));
      send_request(len, $urandom(), 8'($urandom()), 8'($urandom()));
   endtask

   // Lowers the request valid and waits for every expected header to drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_headers.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write, only ever issued once the block has gone idle.
   task automatic write_register(input logic index, input logic [31:0] data);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      if (index == REG_MTU)
         cfg_mtu = data[15:0];
      else
         cfg_local_addr = data;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Result side: random idling, long hold-offs on demand, and field checks.
   always @(posedge clock) begin
      frag_header_type exp_hdr;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_headers.size() == 0) begin
               $display("%0t: header with no request outstanding, ident 0x%0h",
                        $time, rsp_ident);
               error_count++;
            end else begin
               exp_hdr = pending_headers.pop_front();
               check_field("total_length", exp_hdr.total_length, rsp_total_length);
               check_field("ident", exp_hdr.ident, rsp_ident);
               check_field("frag_offset", exp_hdr.frag_offset, rsp_frag_offset);
               check_field("more_fragments", exp_hdr.more_fragments, rsp_more_fragments);
               check_field("dont_fragment", exp_hdr.dont_fragment, rsp_dont_fragment);
               check_field("header_checksum", exp_hdr.header_checksum, rsp_header_checksum);
               check_field("payload_start", exp_hdr.payload_start, rsp_payload_start);
               check_field("last", exp_hdr.last, rsp_last);
               headers_checked++;
            end
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_ready <= ($urandom_range(99) >= 34);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d headers outstanding",
                     $time, quiet_cycles, pending_headers.size());
            $display("ipv4_header_fragmenter test failed");
            $finish;
         end
      end
   end

   // Boundaries at the reset settings, then at the smallest and largest mtu.
   task automatic test_directed_extremes();
      send_request(16'd0, 32'h0000_0000, 8'h00, 8'h00);
      send_request(16'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_request(16'd1480, 32'hC0A8_0001, 8'h10, 8'd6);
      send_request(16'd1481, 32'h0A00_0002, 8'hB8, 8'd17);
      send_request(16'd65515, 32'h7F00_0001, 8'h01, 8'd1);
      send_request(16'd65535, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      write_register(REG_LOCAL_ADDR, 32'hFFFF_FFFF);
      // An mtu of zero behaves as the minimum.
      write_register(REG_MTU, 32'hFFFF_0000);
      send_request(16'd1024, 32'h0101_0101, 8'h55, 8'hAA);
      send_request(16'd1025, 32'hFEFE_FEFE, 8'hAA, 8'h55);
      send_request(16'd2048, 32'h8000_0000, 8'h80, 8'h80);
      send_request(16'd65535, 32'h0000_0001, 8'h7F, 8'h7F);
      write_register(REG_MTU, {16'h0000, MIN_MTU - 16'd1});
      send_request(16'd1025, 32'h1234_5678, 8'h3C, 8'd50);
      write_register(REG_MTU, 32'h0000_FFFF);
      send_request(16'd65515, 32'h8765_4321, 8'hC3, 8'd47);
      send_request(16'd65516, 32'hA5A5_5A5A, 8'h5A, 8'hA5);
      send_request(16'd65535, 32'h5A5A_A5A5, 8'hA5, 8'h5A);
      // Chunk size steps from 1024 to 1032 between these two.
      write_register(REG_MTU, 32'd1051);
      send_request(16'd3000, 32'h0F0F_0F0F, 8'hF0, 8'h0F);
      write_register(REG_MTU, 32'd1052);
      send_request(16'd3000, 32'hF0F0_F0F0, 8'h0F, 8'hF0);
      write_register(REG_LOCAL_ADDR, 32'h0000_0000);
      send_request(16'd9000, 32'h0000_0000, 8'h00, 8'h00);
   endtask

   // Random traffic over a range of mtu and source address settings.
   task automatic test_random_traffic();
      int unsigned round;
      int unsigned n;
      for (round = 0; round < 5; round++) begin
         if (round == 0)
            write_register(REG_MTU, {16'($urandom()), MIN_MTU});
         else if (round == 1)
            write_register(REG_MTU, {16'($urandom()), RESET_MTU});
         else if (round == 2)
            write_register(REG_MTU, {16'($urandom()), 16'($urandom_range(0, 1043))});
         else
            write_register(REG_MTU, {16'($urandom()), 16'($urandom_range(1044, 65535))});
         write_register(REG_LOCAL_ADDR, $urandom());
         for (n = 0; n < 48; n++)
            send_random_request();
      end
   endtask

   // A stretch with no idling on either side.
   task automatic test_back_to_back();
      int unsigned n;
      write_register(REG_MTU, {16'h0000, MIN_MTU});
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (n = 0; n < 80; n++)
         send_random_request();
      wait_idle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long time while requests keep coming.
   task automatic test_result_backpressure();
      int unsigned n;
      write_register(REG_MTU, {16'h0000, RESET_MTU});
      req_idle_on = 1'b0;
      hold_requests++;
      for (n = 0; n < 60; n++)
         send_random_request();
      req_idle_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_traffic();
      test_back_to_back();
      test_result_backpressure();
      wait_idle();
      $display("Covered %0d requests and %0d fragment headers across small, reset and",
               requests_sent, headers_checked);
      $display("largest mtu settings, with random idling, a no-idle stretch and a long stall.");
      if (error_count == 0 && pending_headers.size() == 0)
         $display("ipv4_header_fragmenter test passed");
      else
         $display("ipv4_header_fragmenter test failed");
      $finish;
   end

endmodule
